FILE: rtl/core/rgb_sobel_edge_magnitude_macros.svh
// Assertion macros for the Sobel edge magnitude block.
// Used by the top level; expects clk and rst in scope.
`ifndef RGB_SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define RGB_SOBEL_EDGE_MAGNITUDE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define RSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rse_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies.
package rse_pkg;

  localparam int MAX_LINE    = 4096;
  localparam int COL_W       = $clog2(MAX_LINE);
  localparam int DIM_W       = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [DIM_W-1:0] DIM_MIN    = 13'd3;
  localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_LINE);
  localparam logic [DIM_W-1:0] HEIGHT_MAX = 13'd4096;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ALPHA_MODE   = 2'd2;

  localparam logic [1:0] CH_LAST = 2'd2;

  // One interior pixel ready for the edge unit: the 3x3 colour window,
  // row-major top row first, plus the output alpha and position.
  typedef struct packed {
    logic [8:0][23:0] rgb;
    logic [7:0]       alpha;
    logic [11:0]      col;
    logic [11:0]      row;
    logic             last;
  } rse_job_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

FILE: rtl/core/rse_front.sv
// Front end: pixel intake, two line stores, 3x3 window and position counters.
// Depends on rse_pkg; feeds rse_queue with one job per interior pixel.
module rse_front import rse_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,
  input  logic [DIM_W-1:0] frame_width,
  input  logic [DIM_W-1:0] frame_height,
  input  logic             alpha_mode,
  output logic             push,
  output rse_job_t         job,
  input  logic             full
);

  typedef enum logic [1:0] {F_TAKE, F_READ, F_SHIFT, F_PUSH} fstate_t;

  fstate_t          state;
  logic [31:0]      pix;
  logic [31:0]      top_rd;
  logic [31:0]      mid_rd;
  logic [8:0][31:0] win;
  logic [COL_W-1:0] col;
  logic [11:0]      row;
  logic [11:0]      emit_col;
  logic [11:0]      emit_row;
  logic             emit_last;
  logic             alpha_en;

  logic [31:0] upper_mem  [MAX_LINE];
  logic [31:0] middle_mem [MAX_LINE];

  logic [DIM_W-1:0] w_use, h_use;
  logic             row_end, frame_end, emit;

  always_comb begin
    w_use     = clamp_dim(frame_width, WIDTH_MAX);
    h_use     = clamp_dim(frame_height, HEIGHT_MAX);
    row_end   = ({1'b0, col} + 13'd1) >= w_use;
    frame_end = row_end && (({1'b0, row} + 13'd1) >= h_use);
    emit      = (row >= 12'd2) && (col >= COL_W'(2));
  end

  // Line stores: read in F_READ, write back in F_SHIFT.
  always_ff @(posedge clk) begin
    if (state == F_READ) begin
      top_rd <= upper_mem[col];
      mid_rd <= middle_mem[col];
    end
    if (state == F_SHIFT) begin
      upper_mem[col]  <= mid_rd;
      middle_mem[col] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_TAKE;
      col   <= '0;
      row   <= '0;
    end else begin
      case (state)
        F_TAKE: begin
          if (s_tvalid) begin
            pix   <= s_tdata;
            state <= F_READ;
          end
        end
        F_READ: state <= F_SHIFT;
        F_SHIFT: begin
          for (int r = 0; r < 3; r++) begin
            win[r*3]   <= win[r*3+1];
            win[r*3+1] <= win[r*3+2];
          end
          win[2]    <= top_rd;
          win[5]    <= mid_rd;
          win[8]    <= pix;
          emit_col  <= 12'(col) - 12'd1;
          emit_row  <= row - 12'd1;
          emit_last <= frame_end;
          alpha_en  <= alpha_mode;
          if (row_end) begin
            col <= '0;
            row <= frame_end ? 12'd0 : row + 12'd1;
          end else begin
            col <= col + COL_W'(1);
          end
          state <= emit ? F_PUSH : F_TAKE;
        end
        F_PUSH: begin
          if (!full) state <= F_TAKE;
        end
        default: state <= F_TAKE;
      endcase
    end
  end

  always_comb begin
    s_tready = (state == F_TAKE);
    push     = (state == F_PUSH) && !full;
    for (int k = 0; k < 9; k++) job.rgb[k] = win[k][23:0];
    job.alpha = alpha_en ? win[4][31:24] : 8'd0;
    job.col   = emit_col;
    job.row   = emit_row;
    job.last  = emit_last;
  end

endmodule

FILE: rtl/core/rse_queue.sv
// Short job queue between front and back ends.
// Depends on rse_pkg for the job type and depth.
module rse_queue import rse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  rse_job_t job_in,
  output logic     full,
  input  logic     pop,
  output rse_job_t job_out,
  output logic     empty
);

  rse_job_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr, rptr;
  logic [QCNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + QPTR_W'(1);
      if (pop)  rptr <= rptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign job_out = slots[rptr];

endmodule

FILE: rtl/core/rse_back.sv
// Back end: Sobel gradients per channel and an iterative saturating root.
// Depends on rse_pkg; drains rse_queue and drives the output register.
module rse_back import rse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  rse_job_t    job_in,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,
  output logic        m_tlast
);

  typedef enum logic [2:0] {B_IDLE, B_GRAD, B_SQ, B_SUM, B_ROOT, B_OUT} bstate_t;

  bstate_t      state;
  rse_job_t     job;
  logic [1:0]   ch;
  logic [10:0]  ax, ay;
  logic [20:0]  sqx, sqy;
  logic [20:0]  v;
  logic [7:0]   root;
  logic [2:0]   bitn;
  logic [2:0][7:0] edge_val;

  logic [8:0][7:0]   p;
  logic signed [12:0] gx, gy;
  logic [7:0]   trial;
  logic [15:0]  trial_sq;

  always_comb begin
    for (int k = 0; k < 9; k++) p[k] = job.rgb[k][8*ch +: 8];
    gx = 13'(signed'({5'd0, p[2]})) - 13'(signed'({5'd0, p[0]}))
       + 13'(signed'({4'd0, p[5], 1'b0})) - 13'(signed'({4'd0, p[3], 1'b0}))
       + 13'(signed'({5'd0, p[8]})) - 13'(signed'({5'd0, p[6]}));
    gy = 13'(signed'({5'd0, p[6]})) - 13'(signed'({5'd0, p[0]}))
       + 13'(signed'({4'd0, p[7], 1'b0})) - 13'(signed'({4'd0, p[1], 1'b0}))
       + 13'(signed'({5'd0, p[8]})) - 13'(signed'({5'd0, p[2]}));
    trial    = root | (8'd1 << bitn);
    trial_sq = trial * trial;
  end

  assign pop = (state == B_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != B_OUT)) m_tvalid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!empty) begin
            job   <= job_in;
            ch    <= '0;
            state <= B_GRAD;
          end
        end
        B_GRAD: begin
          ax    <= 11'(gx < 0 ? -gx : gx);
          ay    <= 11'(gy < 0 ? -gy : gy);
          state <= B_SQ;
        end
        B_SQ: begin
          sqx   <= {10'd0, ax} * {10'd0, ax};
          sqy   <= {10'd0, ay} * {10'd0, ay};
          state <= B_SUM;
        end
        B_SUM: begin
          v     <= sqx + sqy;
          root  <= '0;
          bitn  <= 3'd7;
          state <= B_ROOT;
        end
        B_ROOT: begin
          if (v >= 21'd65025) begin
            edge_val[ch] <= 8'd255;
            ch    <= ch + 2'd1;
            state <= (ch == CH_LAST) ? B_OUT : B_GRAD;
          end else if (bitn == 3'd0) begin
            edge_val[ch] <= ({5'd0, trial_sq} <= v) ? trial : root;
            ch    <= ch + 2'd1;
            state <= (ch == CH_LAST) ? B_OUT : B_GRAD;
          end else begin
            if ({5'd0, trial_sq} <= v) root <= trial;
            bitn <= bitn - 3'd1;
          end
        end
        B_OUT: begin
          // Load the output word once the previous one has left; hold otherwise.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {job.alpha, edge_val[2], edge_val[1], edge_val[0],
                         job.row, job.col};
            m_tlast  <= job.last;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/rgb_sobel_edge_magnitude.sv
// Top level of the RGBA Sobel edge magnitude block.
// Depends on rse_pkg, rse_front, rse_queue, rse_back and the macro header.
//
// Takes RGBA pixels in raster order (red in s_tdata[7:0] up to alpha in
// [31:24]) and emits one word per interior pixel: its column and row, the
// saturated Sobel magnitude floor(sqrt(gx^2+gy^2)) of red, green and blue,
// and the centre alpha when alpha mode is set (zero otherwise). m_tlast
// marks the last interior pixel of a frame. Border pixels produce no word;
// the receiver fills them in. The front end takes every pixel through
// F_TAKE, F_READ and F_SHIFT (and F_PUSH, which waits while the queue is
// full, to hand off an interior pixel) because each pixel makes one read
// and one write of the single-ported line stores. The back end takes the
// job in B_IDLE, then per channel runs B_GRAD, B_SQ, B_SUM and the
// bit-serial root in B_ROOT (cut short when the channel saturates), shared
// by the three channels, and loads the output word in B_OUT; it takes no
// new job before then. A two-entry queue between them lets the front keep
// taking border pixels while the back works, so the sustained rate on a
// large frame is set by the root unit. Width and height are clamped to
// 3..4096 and take effect on the next pixel; write the registers only while idle.
`include "rgb_sobel_edge_magnitude_macros.svh"
module rgb_sobel_edge_magnitude import rse_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // red, green, blue, alpha_in (8 bits each)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // col_out(12), row_out(12), red_edge, green_edge,
                                 // blue_edge, alpha_out (8 each)
  output logic        m_tlast,   // frame_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic             alpha_mode;

  logic     q_push, q_full, q_pop, q_empty;
  rse_job_t q_in, q_out;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes drop silently.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 13'd640;
      frame_height <= 13'd480;
      alpha_mode   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_ALPHA_MODE:   alpha_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rse_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .frame_width, .frame_height, .alpha_mode,
    .push(q_push), .job(q_in), .full(q_full)
  );

  rse_queue u_queue (
    .clk, .rst, .push(q_push), .job_in(q_in), .full(q_full),
    .pop(q_pop), .job_out(q_out), .empty(q_empty)
  );

  rse_back u_back (
    .clk, .rst, .empty(q_empty), .job_in(q_out), .pop(q_pop),
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  `RSE_ASSERT_NOW(a_no_overflow, q_push, !q_full, "job pushed into full queue")
  `RSE_ASSERT_NOW(a_no_underflow, q_pop, !q_empty, "job popped from empty queue")
  `RSE_ASSERT_NOW(a_interior_pos, m_tvalid,
                  (m_tdata[11:0] != 12'd0) && (m_tdata[23:12] != 12'd0),
                  "border position on output")
  `RSE_ASSERT_NEXT(a_width_write, cfg_valid && (cfg_index == REG_FRAME_WIDTH),
                   frame_width == $past(cfg_data), "frame width write lost")

endmodule
